FILE: src/dlf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dlf_pkg: shared types and constants for the dense layer
// Field widths, request and mode codes, queue entry and state types.
// ============================================================================
package dlf_pkg;

    // fixed-point format and field widths
    localparam int FRAC_BITS  = 12;
    localparam int DATA_W     = 16;
    localparam int NIDX_W     = 4;
    localparam int IIDX_W     = 6;
    localparam int REQ_W      = 2;
    localparam int MODE_W     = 2;
    localparam int INUSE_W    = 7;
    localparam int NUSE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WEIGHT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BIAS   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ELEM   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;   // ignored

    // activation modes (unused code acts as linear)
    localparam logic [MODE_W-1:0] ACT_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] ACT_RELU    = 2'd1;
    localparam logic [MODE_W-1:0] ACT_SIGMOID = 2'd2;
    localparam logic [MODE_W-1:0] ACT_SPARE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEURONS = 2'd2;

    // bias reset: 0.01 rounded to the fixed-point grid
    localparam logic signed [DATA_W-1:0] BIAS_RESET =
        DATA_W'(((1 << FRAC_BITS) + 50) / 100);

    // sigmoid arithmetic, Q30
    localparam int Q_SHIFT = 30;
    localparam int Y_W     = 26;   // |x| << 10 fits 26 bits
    localparam int E_W     = 31;   // values up to 1.0 in Q30
    localparam int MUL_W   = 31;
    localparam logic [E_W-1:0] Q30_ONE = 31'h4000_0000;
    // reciprocals for y^3/6 (shift 24) and y^4/24 (shift 20), exact on range
    localparam logic [MUL_W-1:0] RECIP6  = 31'd2796203;
    localparam logic [MUL_W-1:0] RECIP24 = 31'd43691;

    // classified request kinds
    typedef enum logic [1:0] {
        KIND_WEIGHT,
        KIND_BIAS,
        KIND_ELEM,
        KIND_EVAL
    } t_kind;

    // queue entry between front and back
    typedef struct packed {
        t_kind                     kind;
        logic [NIDX_W-1:0]         nidx;
        logic [IIDX_W-1:0]         iidx;
        logic signed [DATA_W-1:0]  value;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_DRAIN,
        BK_ROUND,
        BK_ACT,
        BK_SIGW,
        BK_EMIT
    } t_back_state;

    typedef enum logic [3:0] {
        SG_IDLE,
        SG_Y2,
        SG_Y3,
        SG_D6,
        SG_Y4,
        SG_SERIES,
        SG_SQUARE,
        SG_DIVSET,
        SG_DIV,
        SG_DONE
    } t_sig_state;

endpackage

FILE: src/dense_layer_forward.sv
`timescale 1ns / 1ps
// ============================================================================
// dense_layer_forward: fully connected layer with activation
// Loads weights and biases, buffers an input vector and emits one result per
// neuron when the vector's closing element arrives.
// ============================================================================
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-------------------------------
//  request  | in        | start high, busy low   | req_type, neuron_index,
//           |           |                        | input_index, value
//  result   | out       | o_strobe, one cycle    | out_neuron, pre_activation,
//           |           |                        | activation_value, flags
//  config   | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  A write request is registered in the queue, then stored once the back end is idle.
//  A closing element runs each neuron in turn through the single MAC
//  and, with sigmoid, through the serial divider.
//  busy rises only while the two-entry request queue is full.
//  Synchronous active-low reset; biases return to 0.01, other stores keep
//  their contents. Results cannot be held off by the receiver.
//
module dense_layer_forward #(
    parameter int NEURONS_MAX = 16,
    parameter int INPUTS_MAX  = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [dlf_pkg::REQ_W-1:0]             i_req_type,
    input  logic [dlf_pkg::NIDX_W-1:0]            i_neuron_index,
    input  logic [dlf_pkg::IIDX_W-1:0]            i_input_index,
    input  logic signed [dlf_pkg::DATA_W-1:0]     i_value,
    input  logic                                  i_cfg_we,
    input  logic [dlf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dlf_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output logic                                  o_strobe,
    output logic [dlf_pkg::NIDX_W-1:0]            o_out_neuron,
    output logic signed [dlf_pkg::DATA_W-1:0]     o_pre_activation,
    output logic signed [dlf_pkg::DATA_W-1:0]     o_activation_value,
    output logic                                  o_sum_saturated,
    output logic                                  o_last_neuron
);
    import dlf_pkg::*;

    localparam int IN_LIMIT  = (INPUTS_MAX < 64) ? INPUTS_MAX : 64;
    localparam int NEU_LIMIT = (NEURONS_MAX < 16) ? NEURONS_MAX : 16;

    logic [MODE_W-1:0]  r_mode;
    logic [INUSE_W-1:0] r_inputs;
    logic [NUSE_W-1:0]  r_neurons;

    logic [INUSE_W-1:0] w_in_v;
    logic [NUSE_W-1:0]  w_neu_v;
    logic [INUSE_W-1:0] w_in_clamp;
    logic [NUSE_W-1:0]  w_neu_clamp;

    t_job               w_job;
    logic               w_job_valid;
    logic               w_job_pop;

    // clamp counts into their legal range
    assign w_in_v  = i_cfg_data[INUSE_W-1:0];
    assign w_neu_v = i_cfg_data[NUSE_W-1:0];
    assign w_in_clamp = (w_in_v == '0) ? INUSE_W'(1) :
                        (int'(w_in_v) > IN_LIMIT) ? INUSE_W'(IN_LIMIT) : w_in_v;
    assign w_neu_clamp = (w_neu_v == '0) ? NUSE_W'(1) :
                         (int'(w_neu_v) > NEU_LIMIT) ? NUSE_W'(NEU_LIMIT) : w_neu_v;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ACT_LINEAR;
            r_inputs  <= INUSE_W'(IN_LIMIT);
            r_neurons <= NUSE_W'(NEU_LIMIT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_INPUTS:  r_inputs  <= w_in_clamp;
                CFG_NEURONS: r_neurons <= w_neu_clamp;
                default: begin
                end
            endcase
        end
    end

    dlf_front #(
        .NEURONS_MAX (NEURONS_MAX),
        .INPUTS_MAX  (INPUTS_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_req_type      (i_req_type),
        .i_nidx          (i_neuron_index),
        .i_iidx          (i_input_index),
        .i_value         (i_value),
        .i_inputs_in_use (r_inputs),
        .o_job           (w_job),
        .o_job_valid     (w_job_valid),
        .i_job_pop       (w_job_pop)
    );

    dlf_back #(
        .NEURONS_MAX (NEURONS_MAX),
        .INPUTS_MAX  (INPUTS_MAX)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (w_job),
        .i_job_valid      (w_job_valid),
        .o_job_pop        (w_job_pop),
        .i_mode           (r_mode),
        .i_inputs_in_use  (r_inputs),
        .i_neurons_in_use (r_neurons),
        .o_strobe         (o_strobe),
        .o_out_neuron     (o_out_neuron),
        .o_pre            (o_pre_activation),
        .o_act            (o_activation_value),
        .o_sat            (o_sum_saturated),
        .o_last           (o_last_neuron)
    );

endmodule

FILE: src/dlf_sigmoid.sv
`timescale 1ns / 1ps
// ============================================================================
// dlf_sigmoid: iterative fixed-point sigmoid
// One shared multiplier steps through the exp series and eight squarings,
// then a restoring divider forms the ratio one quotient bit per cycle.
// ============================================================================
module dlf_sigmoid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic signed [dlf_pkg::DATA_W-1:0] i_x,
    output logic                              o_done,
    output logic signed [dlf_pkg::DATA_W-1:0] o_y
);
    import dlf_pkg::*;

    t_sig_state r_state, n_state;

    logic                r_pos;
    logic [Y_W-1:0]      r_y;
    logic [20:0]         r_y2;
    logic [15:0]         r_y3;
    logic [13:0]         r_d6;
    logic [10:0]         r_y4;
    logic [E_W-1:0]      r_e;
    logic [3:0]          r_cnt;
    logic [42:0]         r_rem;
    logic [43:0]         r_dsh;
    logic [12:0]         r_q;

    logic [DATA_W-1:0]   w_xu;
    logic [DATA_W-1:0]   w_ax;
    logic [MUL_W-1:0]    w_ma;
    logic [MUL_W-1:0]    w_mb;
    logic [2*MUL_W-1:0]  w_p;
    logic [2*MUL_W-1:0]  w_sq;
    logic [31:0]         w_series;
    logic [31:0]         w_den;
    logic [42:0]         w_num;
    logic                w_ge;

    assign w_xu = i_x;
    assign w_ax = i_x[DATA_W-1] ? (~w_xu + 16'd1) : w_xu;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            SG_Y2: begin
                w_ma = MUL_W'(r_y);
                w_mb = MUL_W'(r_y);
            end
            SG_Y3: begin
                w_ma = MUL_W'(r_y2);
                w_mb = MUL_W'(r_y);
            end
            SG_D6: begin
                w_ma = MUL_W'(r_y3);
                w_mb = RECIP6;
            end
            SG_Y4: begin
                w_ma = MUL_W'(r_y3);
                w_mb = MUL_W'(r_y);
            end
            SG_SERIES: begin
                w_ma = MUL_W'(r_y4);
                w_mb = RECIP24;
            end
            SG_SQUARE: begin
                w_ma = r_e;
                w_mb = r_e;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_p  = w_ma * w_mb;
    assign w_sq = w_p + (62'd1 << (Q_SHIFT - 1));

    // exp(-y) series: 1 - y + y^2/2 - y^3/6 + y^4/24
    assign w_series = 32'(Q30_ONE) - 32'(r_y) + 32'(r_y2 >> 1) - 32'(r_d6)
                    + 32'(w_p[26:20]);

    assign w_den = 32'(Q30_ONE) + 32'(r_e);
    assign w_num = r_pos ? (43'(Q30_ONE) << FRAC_BITS) : (43'(r_e) << FRAC_BITS);
    assign w_ge  = ({1'b0, r_rem} >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and done strobe
    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            SG_IDLE:   if (i_go) n_state = SG_Y2;
            SG_Y2:     n_state = SG_Y3;
            SG_Y3:     n_state = SG_D6;
            SG_D6:     n_state = SG_Y4;
            SG_Y4:     n_state = SG_SERIES;
            SG_SERIES: n_state = SG_SQUARE;
            SG_SQUARE: if (r_cnt == 4'd7) n_state = SG_DIVSET;
            SG_DIVSET: n_state = SG_DIV;
            SG_DIV:    if (r_cnt == 4'd0) n_state = SG_DONE;
            SG_DONE: begin
                o_done  = 1'b1;
                n_state = SG_IDLE;
            end
            default:   n_state = SG_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            SG_IDLE: begin
                r_pos <= ~i_x[DATA_W-1];
                r_y   <= Y_W'(w_ax) << (Q_SHIFT - FRAC_BITS - 8);
            end
            SG_Y2:     r_y2 <= w_p[50:30];
            SG_Y3:     r_y3 <= w_p[45:30];
            SG_D6:     r_d6 <= w_p[37:24];
            SG_Y4:     r_y4 <= w_p[40:30];
            SG_SERIES: begin
                r_e   <= w_series[E_W-1:0];
                r_cnt <= 4'd0;
            end
            SG_SQUARE: begin
                r_e   <= w_sq[60:30];
                r_cnt <= r_cnt + 4'd1;
            end
            SG_DIVSET: begin
                r_dsh <= {w_den, 12'd0};
                r_rem <= w_num + 43'(w_den >> 1);
                r_q   <= '0;
                r_cnt <= 4'd12;
            end
            SG_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[42:0];
                end
                r_q   <= {r_q[11:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 4'd1;
            end
            default: begin
            end
        endcase
    end

    // quotient never exceeds 4096
    assign o_y = DATA_W'(r_q);

endmodule

FILE: src/dlf_front.sv
`timescale 1ns / 1ps
// ============================================================================
// dlf_front: request intake and classification
// Drops out-of-range or unused requests, tags the vector's closing element,
// and holds accepted requests in a two-entry queue for the back end.
// ============================================================================
module dlf_front #(
    parameter int NEURONS_MAX = 16,
    parameter int INPUTS_MAX  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [dlf_pkg::REQ_W-1:0]          i_req_type,
    input  logic [dlf_pkg::NIDX_W-1:0]         i_nidx,
    input  logic [dlf_pkg::IIDX_W-1:0]         i_iidx,
    input  logic signed [dlf_pkg::DATA_W-1:0]  i_value,
    input  logic [dlf_pkg::INUSE_W-1:0]        i_inputs_in_use,
    output dlf_pkg::t_job                      o_job,
    output logic                               o_job_valid,
    input  logic                               i_job_pop
);
    import dlf_pkg::*;

    t_job         r_q [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    logic         w_n_ok;
    logic         w_i_ok;
    logic         w_keep;
    t_kind        w_kind;
    logic         w_push;
    logic         w_pop;

    assign w_n_ok = int'(i_nidx) < NEURONS_MAX;
    assign w_i_ok = int'(i_iidx) < INPUTS_MAX;

    // classify the request
    always_comb begin
        w_keep = 1'b0;
        w_kind = KIND_ELEM;
        case (i_req_type)
            REQ_WEIGHT: begin
                w_keep = w_n_ok && w_i_ok;
                w_kind = KIND_WEIGHT;
            end
            REQ_BIAS: begin
                w_keep = w_n_ok;
                w_kind = KIND_BIAS;
            end
            REQ_ELEM: begin
                w_keep = w_i_ok;
                w_kind = ({1'b0, i_iidx} == (i_inputs_in_use - 7'd1)) ? KIND_EVAL
                                                                       : KIND_ELEM;
            end
            default: begin
                w_keep = 1'b0;
                w_kind = KIND_ELEM;
            end
        endcase
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start && !o_busy && w_keep;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{kind: w_kind, nidx: i_nidx, iidx: i_iidx, value: i_value};
        end
    end

endmodule

FILE: src/dlf_back.sv
`timescale 1ns / 1ps
// ============================================================================
// dlf_back: storage and evaluation engine
// Performs weight, bias and element writes, and on the closing element runs
// one multiply-accumulate per cycle per neuron, rounds, saturates and applies
// the activation before emitting the neuron's result.
// ============================================================================
module dlf_back #(
    parameter int NEURONS_MAX = 16,
    parameter int INPUTS_MAX  = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dlf_pkg::t_job                      i_job,
    input  logic                               i_job_valid,
    output logic                               o_job_pop,
    input  logic [dlf_pkg::MODE_W-1:0]         i_mode,
    input  logic [dlf_pkg::INUSE_W-1:0]        i_inputs_in_use,
    input  logic [dlf_pkg::NUSE_W-1:0]         i_neurons_in_use,
    output logic                               o_strobe,
    output logic [dlf_pkg::NIDX_W-1:0]         o_out_neuron,
    output logic signed [dlf_pkg::DATA_W-1:0]  o_pre,
    output logic signed [dlf_pkg::DATA_W-1:0]  o_act,
    output logic                               o_sat,
    output logic                               o_last
);
    import dlf_pkg::*;

    localparam int WDEPTH = NEURONS_MAX * INPUTS_MAX;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int IA_W   = (INPUTS_MAX > 1) ? $clog2(INPUTS_MAX) : 1;
    localparam int NA_W   = (NEURONS_MAX > 1) ? $clog2(NEURONS_MAX) : 1;
    localparam int ACC_W  = 2 * DATA_W + IA_W + 2;

    t_back_state r_state, n_state;

    logic signed [DATA_W-1:0]   r_wmem [WDEPTH];
    logic signed [DATA_W-1:0]   r_xbuf [INPUTS_MAX];
    logic signed [DATA_W-1:0]   r_bias [NEURONS_MAX];

    logic [NIDX_W-1:0]          r_neu;
    logic [INUSE_W-1:0]         r_idx;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_v1;
    logic                       r_v2;
    logic signed [DATA_W-1:0]   r_wq;
    logic signed [DATA_W-1:0]   r_xq;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [DATA_W-1:0]   r_pre;
    logic signed [DATA_W-1:0]   r_act;
    logic                       r_sat;

    logic                       w_take;
    logic                       w_issue;
    logic                       w_last_issue;
    logic                       w_last_neu;
    logic                       w_sig_go;
    logic                       w_sig_done;
    logic signed [DATA_W-1:0]   w_sig_y;
    logic [WA_W-1:0]            w_wr_addr;
    logic [WA_W-1:0]            w_rd_addr;
    logic signed [ACC_W-1:0]    w_rnd;
    logic signed [ACC_W-1:0]    w_q;
    logic                       w_ovf;
    logic [NA_W-1:0]            w_bias_idx;

    assign w_take       = (r_state == BK_IDLE) && i_job_valid;
    assign o_job_pop    = w_take;
    assign w_wr_addr    = WA_W'(int'(i_job.nidx) * INPUTS_MAX + int'(i_job.iidx));
    assign w_rd_addr    = WA_W'(int'(r_neu) * INPUTS_MAX + int'(r_idx));
    assign w_last_issue = (r_idx == (i_inputs_in_use - 7'd1));
    assign w_last_neu   = ({1'b0, r_neu} == (i_neurons_in_use - 5'd1));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state  = r_state;
        w_issue  = 1'b0;
        w_sig_go = 1'b0;
        o_strobe = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (w_take && i_job.kind == KIND_EVAL) n_state = BK_MAC;
            end
            BK_MAC: begin
                w_issue = 1'b1;
                if (w_last_issue) n_state = BK_DRAIN;
            end
            BK_DRAIN: begin
                if (!r_v1 && !r_v2) n_state = BK_ROUND;
            end
            BK_ROUND: n_state = BK_ACT;
            BK_ACT: begin
                if (i_mode == ACT_SIGMOID) begin
                    w_sig_go = 1'b1;
                    n_state  = BK_SIGW;
                end else begin
                    n_state = BK_EMIT;
                end
            end
            BK_SIGW: begin
                if (w_sig_done) n_state = BK_EMIT;
            end
            BK_EMIT: begin
                o_strobe = 1'b1;
                n_state  = w_last_neu ? BK_IDLE : BK_MAC;
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // weight and element stores
    always_ff @(posedge i_clk) begin
        if (w_take && i_job.kind == KIND_WEIGHT) begin
            r_wmem[w_wr_addr] <= i_job.value;
        end
        if (w_take && (i_job.kind == KIND_ELEM || i_job.kind == KIND_EVAL)) begin
            r_xbuf[IA_W'(i_job.iidx)] <= i_job.value;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_wq <= r_wmem[w_rd_addr];
        r_xq <= r_xbuf[IA_W'(r_idx)];
    end

    // bias store, reset to 0.01
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEURONS_MAX; i++) begin
                r_bias[i] <= BIAS_RESET;
            end
        end else if (w_take && i_job.kind == KIND_BIAS) begin
            r_bias[NA_W'(i_job.nidx)] <= i_job.value;
        end
    end

    // MAC pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
        end
    end

    // round half up, then saturate to 16 bits
    assign w_rnd = r_acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign w_q   = w_rnd >>> FRAC_BITS;
    assign w_ovf = (w_q[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){1'b0}})
                && (w_q[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){1'b1}});

    assign w_bias_idx = (r_state == BK_IDLE) ? NA_W'(0) : NA_W'(r_neu + 4'd1);

    // evaluation datapath
    always_ff @(posedge i_clk) begin
        r_prod <= r_wq * r_xq;
        if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        case (r_state)
            BK_IDLE: begin
                r_neu <= '0;
                r_idx <= '0;
                r_acc <= ACC_W'(r_bias[w_bias_idx]) <<< FRAC_BITS;
            end
            BK_MAC: r_idx <= r_idx + 7'd1;
            BK_ROUND: begin
                r_sat <= w_ovf;
                if (w_ovf) begin
                    r_pre <= w_q[ACC_W-1] ? 16'sh8000 : 16'sh7FFF;
                end else begin
                    r_pre <= w_q[DATA_W-1:0];
                end
            end
            BK_ACT: begin
                if (i_mode == ACT_RELU) begin
                    r_act <= r_pre[DATA_W-1] ? '0 : r_pre;
                end else begin
                    r_act <= r_pre;
                end
            end
            BK_SIGW: begin
                if (w_sig_done) r_act <= w_sig_y;
            end
            BK_EMIT: begin
                r_neu <= r_neu + 4'd1;
                r_idx <= '0;
                r_acc <= ACC_W'(r_bias[w_bias_idx]) <<< FRAC_BITS;
            end
            default: begin
            end
        endcase
    end

    dlf_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_sig_go),
        .i_x     (r_pre),
        .o_done  (w_sig_done),
        .o_y     (w_sig_y)
    );

    assign o_out_neuron = r_neu;
    assign o_pre        = r_pre;
    assign o_act        = r_act;
    assign o_sat        = r_sat;
    assign o_last       = w_last_neu;

endmodule

FILE: src/dlf_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// dlf_checker: port-level assertions for the dense layer
// Watches result strobes, saturation flags and reset behavior.
// ============================================================================
module dlf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_sum_saturated,
    input logic [15:0] o_pre_activation
);

    // results never come in adjacent cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !busy)
        else $error("activity right after reset");

    // a saturated sum sits on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_sum_saturated |->
            o_pre_activation == 16'h7FFF || o_pre_activation == 16'h8000)
        else $error("saturation flag without rail value");

endmodule

bind dense_layer_forward dlf_checker u_dlf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_strobe         (o_strobe),
    .o_sum_saturated  (o_sum_saturated),
    .o_pre_activation (o_pre_activation)
);

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for dense_layer_forward
// Loads weights and biases, sends input vectors under every activation mode
// and many layer sizes, predicts each neuron result and compares field by
// field as results come out. Requests go back to back or with random gaps.
// ============================================================================
module testbench;
    import dlf_pkg::*;

    localparam int QUIET_CYCLES = 60;     // settle time before a config write
    localparam int CYCLE_LIMIT  = 1000000;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // one pending request or register write
    typedef struct {
        bit                        is_cfg;
        logic [CFG_IDX_W-1:0]      cidx;
        logic [CFG_DATA_W-1:0]     cdata;
        logic [REQ_W-1:0]          req;
        logic [NIDX_W-1:0]         nidx;
        logic [IIDX_W-1:0]         iidx;
        logic signed [DATA_W-1:0]  val;
        int                        gap;
    } t_pending;

    // one neuron result
    typedef struct {
        logic [NIDX_W-1:0]         neuron;
        logic signed [DATA_W-1:0]  pre;
        logic signed [DATA_W-1:0]  act;
        logic                      sat;
        logic                      last;
    } t_neuron_res;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [REQ_W-1:0]            i_req_type = '0;
    logic [NIDX_W-1:0]           i_neuron_index = '0;
    logic [IIDX_W-1:0]           i_input_index = '0;
    logic signed [DATA_W-1:0]    i_value = '0;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                        o_strobe;
    logic [NIDX_W-1:0]           o_out_neuron;
    logic signed [DATA_W-1:0]    o_pre_activation;
    logic signed [DATA_W-1:0]    o_activation_value;
    logic                        o_sum_saturated;
    logic                        o_last_neuron;

    dense_layer_forward dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_neuron_index     (i_neuron_index),
        .i_input_index      (i_input_index),
        .i_value            (i_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_out_neuron       (o_out_neuron),
        .o_pre_activation   (o_pre_activation),
        .o_activation_value (o_activation_value),
        .o_sum_saturated    (o_sum_saturated),
        .o_last_neuron      (o_last_neuron)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_pending    pend_q[$];
    t_neuron_res layer_results[$];
    t_pending    cur_req;
    int          err_count = 0;
    int          gap_left = 0;
    int          quiet = 0;
    int          cycles = 0;

    // predictor state
    logic signed [DATA_W-1:0] w_mem [16][64];
    logic signed [DATA_W-1:0] bias_mem [16];
    logic signed [DATA_W-1:0] vec_mem [64];
    logic [MODE_W-1:0]        act_mode = ACT_LINEAR;
    int                       n_inputs = 64;
    int                       n_neurons = 16;

    // generator's view of sizes and written entries
    bit w_done [16][64];
    bit x_done [64];
    int g_inputs = 64;
    int g_neurons = 16;
    int rand_count = 0;
    bit no_gaps = 0;

    function automatic int clamp_cnt(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // fixed-point logistic of a Q4.12 value
    function automatic logic signed [DATA_W-1:0] logistic_q(logic signed [DATA_W-1:0] x);
        longint unsigned ax, y, y2, y3, y4, e, num, den, r;
        ax = (x < 0) ? longint'(-int'(x)) : longint'(x);
        y  = (ax << 30) >> (FRAC_BITS + 8);
        y2 = (y * y) >> 30;
        y3 = (y2 * y) >> 30;
        y4 = (y3 * y) >> 30;
        e  = ONE_Q30 - y + y2 / 2 - y3 / 6 + y4 / 24;
        for (int k = 0; k < 8; k++)
            e = (e * e + (ONE_Q30 >> 1)) >> 30;
        num = ((x >= 0) ? ONE_Q30 : e) << FRAC_BITS;
        den = ONE_Q30 + e;
        r = (num + den / 2) / den;
        if (r > 32767) r = 32767;
        return DATA_W'(r);
    endfunction

    function automatic t_neuron_res neuron_result(int n);
        t_neuron_res res;
        longint acc, q;
        acc = longint'(bias_mem[n]) * (64'sd1 <<< FRAC_BITS);
        for (int i = 0; i < n_inputs; i++)
            acc += longint'(w_mem[n][i]) * longint'(vec_mem[i]);
        acc += 64'sd1 <<< (FRAC_BITS - 1);
        q = acc >>> FRAC_BITS;
        res.sat = 1'b0;
        if (q > 32767) begin
            q = 32767;
            res.sat = 1'b1;
        end
        if (q < -32768) begin
            q = -32768;
            res.sat = 1'b1;
        end
        res.neuron = NIDX_W'(n);
        res.pre    = DATA_W'(q);
        case (act_mode)
            ACT_RELU:    res.act = (res.pre > 0) ? res.pre : '0;
            ACT_SIGMOID: res.act = logistic_q(res.pre);
            default:     res.act = res.pre;
        endcase
        res.last = (n + 1 == n_neurons);
        return res;
    endfunction

    // update the layer model with an accepted request
    task automatic apply_request(t_pending p);
        case (p.req)
            REQ_WEIGHT: w_mem[p.nidx][p.iidx] = p.val;
            REQ_BIAS:   bias_mem[p.nidx] = p.val;
            REQ_ELEM: begin
                vec_mem[p.iidx] = p.val;
                if (int'(p.iidx) == n_inputs - 1)
                    for (int n = 0; n < n_neurons; n++)
                        layer_results = {layer_results, neuron_result(n)};
            end
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_MODE:    act_mode = d[MODE_W-1:0];
            CFG_INPUTS:  n_inputs = clamp_cnt(int'(d), 64);
            CFG_NEURONS: n_neurons = clamp_cnt(int'(d[4:0]), 16);
            default: ;
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_pending p;
        bit free;
        bit next_start;
        bit next_we;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            next_start = start;
            next_we = 1'b0;
            free = !start;
            if (start && !busy) begin
                apply_request(cur_req);
                next_start = 1'b0;
                free = 1'b1;
                quiet = 0;
            end else if (layer_results.size() != 0) begin
                quiet = 0;
            end else if (!start) begin
                quiet++;
            end
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() != 0) begin
                    p = pend_q[0];
                    if (p.is_cfg) begin
                        // register writes only while the layer is idle
                        if (quiet >= QUIET_CYCLES) begin
                            next_we = 1'b1;
                            i_cfg_index <= p.cidx;
                            i_cfg_data  <= p.cdata;
                            apply_cfg(p.cidx, p.cdata);
                            void'(pend_q.pop_front());
                            gap_left = (pend_q.size() != 0) ? pend_q[0].gap : 0;
                        end
                    end else begin
                        cur_req = p;
                        i_req_type     <= p.req;
                        i_neuron_index <= p.nidx;
                        i_input_index  <= p.iidx;
                        i_value        <= p.val;
                        next_start = 1'b1;
                        void'(pend_q.pop_front());
                        gap_left = (pend_q.size() != 0) ? pend_q[0].gap : 0;
                    end
                end
            end
            i_cfg_we <= next_we;
            start <= next_start;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    // result monitor
    always @(posedge i_clk) begin
        t_neuron_res want;
        if (i_rst_n && o_strobe) begin
            if (layer_results.size() == 0) begin
                report_mismatch("unexpected result, neuron", o_out_neuron, -1);
            end else begin
                want = layer_results.pop_front();
                if (o_out_neuron !== want.neuron)
                    report_mismatch("out_neuron", o_out_neuron, want.neuron);
                if (o_pre_activation !== want.pre)
                    report_mismatch("pre_activation", o_pre_activation, want.pre);
                if (o_activation_value !== want.act)
                    report_mismatch("activation_value", o_activation_value, want.act);
                if (o_sum_saturated !== want.sat)
                    report_mismatch("sum_saturated", o_sum_saturated, want.sat);
                if (o_last_neuron !== want.last)
                    report_mismatch("last_neuron", o_last_neuron, want.last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus building
    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(0, 4095)) - 2048);
        endcase
    endfunction

    task automatic push_req(logic [REQ_W-1:0] req, int n, int i, logic signed [DATA_W-1:0] v);
        t_pending p;
        p.is_cfg = 0;
        p.cidx = '0;
        p.cdata = '0;
        p.req = req;
        p.nidx = NIDX_W'(n);
        p.iidx = IIDX_W'(i);
        p.val = v;
        p.gap = no_gaps ? 0 : $urandom_range(0, 13);
        pend_q = {pend_q, p};
        if (req == REQ_WEIGHT) w_done[n][i] = 1;
        if (req == REQ_ELEM) x_done[i] = 1;
        if (req != REQ_NONE) rand_count++;
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, int d);
        t_pending p;
        p.is_cfg = 1;
        p.cidx = idx;
        p.cdata = CFG_DATA_W'(d);
        p.req = '0;
        p.nidx = '0;
        p.iidx = '0;
        p.val = '0;
        p.gap = 0;
        pend_q = {pend_q, p};
        if (idx == CFG_INPUTS) g_inputs = clamp_cnt(d & 127, 64);
        if (idx == CFG_NEURONS) g_neurons = clamp_cnt(d & 31, 16);
    endtask

    // fill in any weight or element the next evaluation would read, then close
    task automatic run_vector();
        for (int n = 0; n < g_neurons; n++)
            for (int i = 0; i < g_inputs; i++)
                if (!w_done[n][i]) push_req(REQ_WEIGHT, n, i, rand_value());
        for (int i = 0; i < g_inputs - 1; i++)
            if (!x_done[i] || $urandom_range(0, 3) == 0)
                push_req(REQ_ELEM, 0, i, rand_value());
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
                0: push_req(REQ_BIAS, $urandom_range(0, 15), 0, rand_value());
                1: push_req(REQ_NONE, $urandom_range(0, 15), $urandom_range(0, 63),
                            rand_value());
                2: begin
                    int idx;
                    idx = $urandom_range(0, 63);
                    if (idx == g_inputs - 1) idx = (idx + 1) % 64;
                    push_req(REQ_ELEM, $urandom_range(0, 15), idx, rand_value());
                end
                default: push_req(REQ_WEIGHT, $urandom_range(0, g_neurons - 1),
                                  $urandom_range(0, g_inputs - 1), rand_value());
            endcase
        end
        push_req(REQ_ELEM, $urandom_range(0, 15), g_inputs - 1, rand_value());
    endtask

    initial begin
        int phase;
        for (int n = 0; n < 16; n++) begin
            bias_mem[n] = BIAS_RESET;
            for (int i = 0; i < 64; i++) w_mem[n][i] = '0;
        end
        for (int i = 0; i < 64; i++) vec_mem[i] = '0;

        // directed: extremes, saturation, every mode, ignored requests
        push_cfg(CFG_INPUTS, 2);
        push_cfg(CFG_NEURONS, 3);
        push_req(REQ_WEIGHT, 0, 0, 16'sh7FFF);
        push_req(REQ_WEIGHT, 0, 1, 16'sh7FFF);
        push_req(REQ_WEIGHT, 1, 0, 16'sh8000);
        push_req(REQ_WEIGHT, 1, 1, 16'sh8000);
        push_req(REQ_WEIGHT, 2, 0, 16'sh1000);
        push_req(REQ_WEIGHT, 2, 1, 16'shFFFF);
        push_req(REQ_BIAS, 0, 0, 16'sh7FFF);
        push_req(REQ_BIAS, 1, 0, 16'sh8000);
        push_req(REQ_ELEM, 0, 0, 16'sh7FFF);
        push_req(REQ_ELEM, 0, 1, 16'sh0800);
        push_cfg(CFG_MODE, ACT_RELU);
        push_req(REQ_ELEM, 0, 1, 16'sh8000);
        push_cfg(CFG_MODE, ACT_SIGMOID);
        push_req(REQ_ELEM, 15, 1, 16'sh0000);
        push_req(REQ_ELEM, 0, 0, 16'shF000);
        push_req(REQ_ELEM, 0, 1, 16'sh0001);
        push_cfg(CFG_MODE, ACT_SPARE);
        push_req(REQ_NONE, 15, 63, 16'sh7FFF);
        push_req(REQ_ELEM, 0, 63, 16'sh1234);
        push_req(REQ_ELEM, 0, 1, 16'sh7FFF);

        // random phases; the first two hit the size extremes
        rand_count = 0;
        phase = 0;
        while (rand_count < 230) begin
            int d_in, d_neu;
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                d_in = 127;
                d_neu = 1;
            end else if (phase == 1) begin
                d_in = 0;
                d_neu = 31;
            end else begin
                case ($urandom_range(0, 5))
                    0:       d_in = 64;
                    1:       d_in = 0;
                    default: d_in = $urandom_range(1, 8);
                endcase
                d_neu = (d_in == 64) ? $urandom_range(1, 2) : $urandom_range(0, 127);
            end
            push_cfg(CFG_MODE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 3));
            push_cfg(CFG_INPUTS, d_in);
            push_cfg(CFG_NEURONS, d_neu);
            repeat ($urandom_range(1, 3)) run_vector();
            phase++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || start || layer_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/dlf_pkg.sv
src/dlf_sigmoid.sv
src/dlf_front.sv
src/dlf_back.sv
src/dense_layer_forward.sv
src/dlf_checker.sv
test/testbench.sv
